// File: hdl/lhmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU hit/miss tracker.
// No dependencies; the tracker, chain, cell and bench refer to it by scoped names.
package lhmt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } out_item_t;

  typedef struct packed {
    logic [CAP_W-1:0] active_entries;
  } cfg_item_t;

  // Per-item sequencing shared by every cell of the chain
  typedef struct packed {
    logic cmp_en;  // capture the tag compare for the item just accepted
    logic upd_en;  // apply the shift for that item
  } ctl_t;

endpackage

// File: hdl/lhmt_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// Payload type comes from lhmt_pkg at the instantiation site.
interface lhmt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lru_hit_miss_tracker.sv
`timescale 1ns / 1ps
// LRU hit/miss tracker: fully associative key store kept in recency order.
// in_chan (sink) takes one key per item; out_chan (source) returns one
// result item per key: hit flag plus saturating hit and miss totals.
// cfg_chan (sink, always ready) writes active_entries, the capacity; 0 acts
// as 1 and values above ENTRIES act as ENTRIES. Write it only while idle.
// The accept cycle registers the compare in every cell; in ST_UPD the match
// chain resolves and the row of cells shifts.
// No new key is accepted until the last one has been updated; the result is
// written to the output register when that update is applied.
// A stalled receiver holds the result; one more key may be accepted and
// compared, and its update waits until the output register frees up.
// Reset (rst_n, synchronous, active low) empties the store, clears both
// counters and sets the capacity to 16. No clearing pass is needed.
// Depends on lhmt_pkg, lhmt_stream_if, lhmt_chain and lhmt_cell.
module lru_hit_miss_tracker #(
  parameter int ENTRIES = lhmt_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lhmt_stream_if.sink   in_chan,
  lhmt_stream_if.source out_chan,
  lhmt_stream_if.sink   cfg_chan
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [lhmt_pkg::CAP_W-1:0] cap_r;
  logic [lhmt_pkg::KEY_W-1:0] key_r;
  logic [lhmt_pkg::CNT_W-1:0] hits_r, hits_nxt;
  logic [lhmt_pkg::CNT_W-1:0] misses_r, misses_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lhmt_pkg::out_item_t        out_r;
  lhmt_pkg::in_item_t         in_item;
  lhmt_pkg::cfg_item_t        cfg_item;
  lhmt_pkg::ctl_t             ctl;
  logic                       in_acc;
  logic                       upd_go;
  logic                       hit;

  assign in_item  = in_chan.data;
  assign cfg_item = cfg_chan.data;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && (state_r == ST_IDLE);
  assign upd_go         = (state_r == ST_UPD) && (!out_valid_r || out_chan.ready);

  assign ctl.cmp_en = in_acc;
  assign ctl.upd_en = upd_go;

  lhmt_chain #(
    .ENTRIES (ENTRIES)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cap     (cap_r),
    .cmp_key (in_item.key),
    .ins_key (key_r),
    .hit     (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (hit) begin
            if (hits_r != lhmt_pkg::CNT_MAX) begin
              hits_nxt = hits_r + lhmt_pkg::CNT_W'(1);
            end
          end else begin
            if (misses_r != lhmt_pkg::CNT_MAX) begin
              misses_nxt = misses_r + lhmt_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      cap_r       <= lhmt_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      if (cfg_chan.valid) begin
        cap_r <= cfg_item.active_entries;
      end
    end
    if (in_acc) begin
      key_r <= in_item.key;
    end
    if (upd_go) begin
      out_r.hit        <= hit;
      out_r.hit_count  <= hits_nxt;
      out_r.miss_count <= misses_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule

// File: hdl/lhmt_cell.sv
`timescale 1ns / 1ps
// One slot of the recency chain: holds a key, its valid bit and a match flag.
// Depends on lhmt_pkg. Position in the chain is the key's recency rank.
module lhmt_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lhmt_pkg::ctl_t             ctl,
  input  logic                       miss,
  input  logic [lhmt_pkg::CAP_W-1:0] cap,
  input  logic [lhmt_pkg::KEY_W-1:0] cmp_key,
  input  logic [lhmt_pkg::KEY_W-1:0] prev_key,
  input  logic                       prev_valid,
  input  logic                       suf_in,
  output logic                       suf_out,
  output logic [lhmt_pkg::KEY_W-1:0] key_o,
  output logic                       valid_o
);

  logic [lhmt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                       valid_r, valid_nxt;
  logic                       match_r, match_nxt;
  logic                       in_cap;
  logic                       shift;

  // Slot survives a miss only inside the capacity; slot 0 always does.
  assign in_cap  = (IDX == 0) || (IDX < int'(cap));

  // A match here or further down means this slot moves one place older.
  assign suf_out = match_r | suf_in;
  assign shift   = ctl.upd_en & (suf_out | miss);

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = valid_r && (key_r == cmp_key);
    end
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (shift) begin
      key_nxt   = prev_key;
      valid_nxt = prev_valid && (!miss || in_cap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;

endmodule

// File: hdl/lhmt_chain.sv
`timescale 1ns / 1ps
// Row of lhmt_cell slots ordered most recent first, plus the match chain.
// Depends on lhmt_pkg and lhmt_cell.
module lhmt_chain #(
  parameter int ENTRIES = lhmt_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lhmt_pkg::ctl_t             ctl,
  input  logic [lhmt_pkg::CAP_W-1:0] cap,
  input  logic [lhmt_pkg::KEY_W-1:0] cmp_key,
  input  logic [lhmt_pkg::KEY_W-1:0] ins_key,
  output logic                       hit
);

  logic [lhmt_pkg::KEY_W-1:0] key_w   [ENTRIES];
  logic                       valid_w [ENTRIES];
  logic [ENTRIES:0]           suf;
  logic                       miss;

  assign suf[ENTRIES] = 1'b0;
  assign hit          = suf[0];
  assign miss         = ~suf[0];

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic [lhmt_pkg::KEY_W-1:0] prev_key;
    logic                       prev_valid;

    if (j == 0) begin : g_head
      // Head takes the accessed key: new on a miss, same key on a hit
      assign prev_key   = ins_key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = key_w[j-1];
      assign prev_valid = valid_w[j-1];
    end

    lhmt_cell #(
      .IDX (j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .miss       (miss),
      .cap        (cap),
      .cmp_key    (cmp_key),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .suf_in     (suf[j+1]),
      .suf_out    (suf[j]),
      .key_o      (key_w[j]),
      .valid_o    (valid_w[j])
    );
  end

endmodule

// File: bench/lru_hit_miss_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_hit_miss_tracker: a scoreboard class keeps an
// LRU store model and compares every result item with its prediction.
// Depends on lhmt_pkg, lhmt_stream_if and the tracker RTL.
module lru_hit_miss_tracker_tb;

  localparam int ENTRIES    = lhmt_pkg::ENTRIES_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_PHASES   = 8;
  localparam int PHASE_KEYS = 80;
  localparam int POOL_SIZE  = 24;

  typedef logic [lhmt_pkg::KEY_W-1:0] key_t;
  typedef logic [lhmt_pkg::CAP_W-1:0] cap_t;

  typedef struct {
    key_t                key;
    lhmt_pkg::out_item_t res;
  } lookup_exp_t;

  class lru_tag_scoreboard;
    key_t                     tags [ENTRIES];
    logic                     used [ENTRIES];
    logic [3:0]               age  [ENTRIES];
    logic [4:0]               fill;
    logic [lhmt_pkg::CNT_W-1:0] hits, misses;
    cap_t                     cap_reg;
    lookup_exp_t              pending_results[$];
    int unsigned              failures, n_hits, n_misses;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tags[i] = '0;
        used[i] = 1'b0;
        age[i]  = '0;
      end
      fill     = '0;
      hits     = '0;
      misses   = '0;
      cap_reg  = lhmt_pkg::CAP_RESET;
      failures = 0;
      n_hits   = 0;
      n_misses = 0;
    endfunction

    function void set_capacity(cap_t v);
      cap_reg = v;
    endfunction

    function logic [lhmt_pkg::CNT_W-1:0] bump(logic [lhmt_pkg::CNT_W-1:0] v);
      return (v == lhmt_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Predict the result of one accepted key and advance the store
    function void note_access(key_t key);
      int          found, slot;
      cap_t        cap;
      logic [3:0]  r;
      lookup_exp_t e;
      found = -1;
      slot  = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && used[i] && tags[i] == key) found = i;
      if (found >= 0) begin
        r = age[found];
        for (int i = 0; i < ENTRIES; i++)
          if (used[i] && age[i] < r) age[i] = age[i] + 1'b1;
        age[found] = '0;
        hits = bump(hits);
        n_hits++;
      end else begin
        cap = (cap_reg == 0) ? cap_t'(1) : (cap_reg > ENTRIES ? cap_t'(ENTRIES) : cap_reg);
        // full (or capacity lowered): drop everything at rank cap-1 or older
        if (fill >= cap) begin
          for (int i = 0; i < ENTRIES; i++)
            if (used[i] && age[i] >= cap - 1) begin
              used[i] = 1'b0;
              fill    = fill - 1'b1;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (used[i]) age[i] = age[i] + 1'b1;
          else if (slot < 0) slot = i;
        end
        if (slot >= 0) begin
          tags[slot] = key;
          used[slot] = 1'b1;
          age[slot]  = '0;
          fill       = fill + 1'b1;
        end
        misses = bump(misses);
        n_misses++;
      end
      e.key            = key;
      e.res.hit        = (found >= 0);
      e.res.hit_count  = hits;
      e.res.miss_count = misses;
      pending_results.push_back(e);
    endfunction

    function void check_result(lhmt_pkg::out_item_t got);
      lookup_exp_t e;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result item: hit=%0d hit_count=%0d miss_count=%0d",
                   got.hit, got.hit_count, got.miss_count);
        return;
      end
      e = pending_results.pop_front();
      if (got.hit !== e.res.hit || got.hit_count !== e.res.hit_count ||
          got.miss_count !== e.res.miss_count) begin
        failures++;
        if (failures <= 10)
          $display("mismatch key %h: exp hit=%0d hc=%0d mc=%0d, got hit=%0d hc=%0d mc=%0d",
                   e.key, e.res.hit, e.res.hit_count, e.res.miss_count,
                   got.hit, got.hit_count, got.miss_count);
      end
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lhmt_stream_if #(.T(lhmt_pkg::in_item_t))  in_if  ();
  lhmt_stream_if #(.T(lhmt_pkg::out_item_t)) out_if ();
  lhmt_stream_if #(.T(lhmt_pkg::cfg_item_t)) cfg_if ();

  lru_hit_miss_tracker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  lru_tag_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cfg_writes    = 0;
  int unsigned idle_cycles   = 0;
  key_t        key_pool [POOL_SIZE];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // receiver side: random backpressure
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("lru_hit_miss_tracker_tb NOT OK");
      $finish;
    end
  end

  task automatic send_key(input key_t k);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= k;
    do @(posedge clk); while (!in_if.ready);
    sb.note_access(k);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input cap_t v);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_capacity(v);
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic key_t pick_key(int window);
    int r;
    r = $urandom_range(99);
    if (r < 80) return key_pool[$urandom_range(window - 1)];
    if (r < 90) return $urandom;
    // near miss: one bit off a pooled key
    return key_pool[$urandom_range(window - 1)] ^ (key_t'(1) << $urandom_range(31));
  endfunction

  initial begin
    cap_t caps [N_PHASES];
    int   snd  [4];
    int   rcv  [4];
    int   eff, window;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd8, 5'd2, 5'd12};
    snd  = '{0, 47, 0, 38};
    rcv  = '{0, 0, 47, 38};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset capacity, extremes of the key, fill to full, evict LRU
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    for (int k = 1; k <= 15; k++) send_key(key_t'(k));
    send_key(32'h0000_0000);
    send_key(32'h0000_000F);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    // capacity lowered below occupancy; a hit first, then a trimming miss
    write_capacity(5'd3);
    send_key(32'h5555_5555);
    send_key(32'h1234_5678);
    send_key(32'hAAAA_AAAA);
    send_key(32'h0000_000E);

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(caps[p]);
      send_idle_pct = snd[p % 4];
      recv_idle_pct = rcv[p % 4];
      eff    = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES ? ENTRIES : caps[p]);
      window = (eff + 3 > POOL_SIZE) ? POOL_SIZE : eff + 3;
      for (int n = 0; n < PHASE_KEYS; n++) send_key(pick_key(window));
    end

    wait_drained();
    repeat (10) @(posedge clk);
    sb.failures += sb.pending_count();

    $display("covered %0d keys (%0d hits, %0d misses) over %0d capacity writes",
             sb.n_hits + sb.n_misses, sb.n_hits, sb.n_misses, cfg_writes);
    $display("capacities 0..31 incl. out-of-range, shrink below occupancy, 4 idle mixes");
    if (sb.failures == 0)
      $display("lru_hit_miss_tracker_tb OK");
    else
      $display("lru_hit_miss_tracker_tb NOT OK");
    $finish;
  end

endmodule
